// ===== hdl/spf_pkg.sv =====
package spf_pkg;

  localparam int SERVO_COUNT = 7;
  localparam int PKT_LEN     = 13;
  localparam int IDX_W       = 3;
  localparam int POS_W       = 16;
  localparam int SPD_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] LEN_BYTE    = 8'h09;
  localparam logic [7:0] INSTR_WRITE = 8'h03;
  localparam logic [7:0] ADDR_GOAL   = 8'h2A;
  localparam logic [7:0] ZERO_BYTE   = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_FIRST_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_BASE      = 3'd1;

  localparam logic [SERVO_COUNT-1:0] MASK_RESET = 7'h54;
  localparam logic [SERVO_COUNT-1:0][SPD_W-1:0] SPEED_RESET = {
    16'd0, 16'd1023, 16'd0, 16'd1023, 16'd0, 16'd0, 16'd0
  };

  typedef struct packed {
    logic [IDX_W-1:0] servo_index;
    logic [POS_W-1:0] target_position;
  } req_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } pkt_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } cell_t;

  typedef logic [PKT_LEN-1:0][7:0] pkt_bytes_t;

endpackage

// ===== hdl/spf_cell.sv =====
module spf_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  logic           load,
  input  spf_pkg::cell_t load_data,
  input  spf_pkg::cell_t nbr,
  output spf_pkg::cell_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (load) begin
      q.valid <= load_data.valid;
    end else if (shift) begin
      q.valid <= nbr.valid;
    end
    if (load) begin
      q.data <= load_data.data;
      q.last <= load_data.last;
    end else if (shift) begin
      q.data <= nbr.data;
      q.last <= nbr.last;
    end
  end

endmodule

// ===== hdl/spf_builder.sv =====
module spf_builder (
  input  logic [spf_pkg::IDX_W-1:0] servo_index,
  input  logic [spf_pkg::POS_W-1:0] position,
  input  logic [spf_pkg::SPD_W-1:0] speed,
  input  logic                      high_first,
  output spf_pkg::pkt_bytes_t       bytes
);

  logic [7:0] id_byte;
  logic [7:0] pos_a;
  logic [7:0] pos_b;
  logic [7:0] spd_a;
  logic [7:0] spd_b;
  logic [7:0] sum_hdr;
  logic [7:0] sum_pos;
  logic [7:0] sum_spd;
  logic [7:0] sum_all;

  assign id_byte = 8'(servo_index) + 8'd1;
  assign pos_a   = high_first ? position[15:8] : position[7:0];
  assign pos_b   = high_first ? position[7:0]  : position[15:8];
  assign spd_a   = high_first ? speed[15:8]    : speed[7:0];
  assign spd_b   = high_first ? speed[7:0]     : speed[15:8];

  // bytes 2 to 11
  assign sum_hdr = id_byte + spf_pkg::LEN_BYTE + spf_pkg::INSTR_WRITE + spf_pkg::ADDR_GOAL;
  assign sum_pos = pos_a + pos_b + spf_pkg::ZERO_BYTE + spf_pkg::ZERO_BYTE;
  assign sum_spd = spd_a + spd_b;
  assign sum_all = sum_hdr + sum_pos + sum_spd;

  always_comb begin
    bytes[0]  = spf_pkg::HDR_BYTE;
    bytes[1]  = spf_pkg::HDR_BYTE;
    bytes[2]  = id_byte;
    bytes[3]  = spf_pkg::LEN_BYTE;
    bytes[4]  = spf_pkg::INSTR_WRITE;
    bytes[5]  = spf_pkg::ADDR_GOAL;
    bytes[6]  = pos_a;
    bytes[7]  = pos_b;
    bytes[8]  = spf_pkg::ZERO_BYTE;
    bytes[9]  = spf_pkg::ZERO_BYTE;
    bytes[10] = spd_a;
    bytes[11] = spd_b;
    bytes[12] = ~sum_all;
  end

endmodule

// ===== hdl/servo_position_packet_framer.sv =====
// channel  dir  handshake              payload
// req      in   req_valid / req_ready  servo_index, target_position
// pkt      out  pkt_valid / pkt_ready  packet_byte, last_byte
// cfg      in   cfg_we                 cfg_index, cfg_data
//
// one request gives 13 bytes, one per cycle while pkt_ready is high; the byte
// chain sends packets back to back with no gap between them.
// a request sits in a one-entry holding register until the chain drains, so
// the next one is taken while the current packet is still going out.
// a servo_index of 7 or more is taken and gives no packet.
// rst is synchronous; it empties the chain and restores the register values.
module servo_position_packet_framer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  spf_pkg::req_t                      req,
  output logic                               pkt_valid,
  input  logic                               pkt_ready,
  output spf_pkg::pkt_t                      pkt,
  input  logic                               cfg_we,
  input  logic [spf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int N = spf_pkg::PKT_LEN;

  logic [spf_pkg::SERVO_COUNT-1:0]                    high_first_mask;
  logic [spf_pkg::SERVO_COUNT-1:0][spf_pkg::SPD_W-1:0] speed;

  logic                      stage_valid;
  logic [spf_pkg::IDX_W-1:0] stage_idx;
  logic [spf_pkg::POS_W-1:0] stage_pos;

  spf_pkg::cell_t      cq [N];
  spf_pkg::cell_t      cload [N];
  spf_pkg::pkt_bytes_t bytes;
  logic [N-1:0]        cv;
  logic                advance;
  logic                chain_free;
  logic                stage_load;
  logic                req_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      high_first_mask <= spf_pkg::MASK_RESET;
      speed           <= spf_pkg::SPEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        spf_pkg::REG_HIGH_FIRST_MASK: begin
          high_first_mask <= cfg_data[spf_pkg::SERVO_COUNT-1:0];
        end
        default: begin
          speed[3'(cfg_index - spf_pkg::REG_SPEED_BASE)] <= cfg_data;
        end
      endcase
    end
  end

  // holding register
  assign advance    = !cv[0] || pkt_ready;
  assign chain_free = advance && !(|cv[N-1:1]);
  assign stage_load = stage_valid && chain_free;
  assign req_ready  = !stage_valid || stage_load;
  assign req_take   = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_take) begin
      stage_valid <= (req.servo_index < 3'(spf_pkg::SERVO_COUNT));
    end else if (stage_load) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      stage_idx <= req.servo_index;
      stage_pos <= req.target_position;
    end
  end

  spf_builder u_builder (
    .servo_index (stage_idx),
    .position    (stage_pos),
    .speed       (speed[stage_idx]),
    .high_first  (high_first_mask[stage_idx]),
    .bytes       (bytes)
  );

  // byte chain, cell 0 drives the output
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign cload[i].valid = 1'b1;
    assign cload[i].data  = bytes[i];
    assign cload[i].last  = (i == N - 1);
    assign cv[i]          = cq[i].valid;

    if (i == N - 1) begin : g_tail
      spf_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (advance),
        .load      (stage_load),
        .load_data (cload[i]),
        .nbr       ('0),
        .q         (cq[i])
      );
    end else begin : g_body
      spf_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (advance),
        .load      (stage_load),
        .load_data (cload[i]),
        .nbr       (cq[i+1]),
        .q         (cq[i])
      );
    end
  end

  assign pkt_valid       = cq[0].valid;
  assign pkt.packet_byte = cq[0].data;
  assign pkt.last_byte   = cq[0].last;

`ifndef NO_ASSERTIONS
  a_last_ends_chain: assert property (@(posedge clk) disable iff (rst)
    (pkt_valid && pkt.last_byte) |-> !(|cv[N-1:1]))
    else $error("last byte has bytes behind it");

  a_load_starts_header: assert property (@(posedge clk) disable iff (rst)
    stage_load |=> (pkt_valid && pkt.packet_byte == spf_pkg::HDR_BYTE && !pkt.last_byte))
    else $error("packet load did not start with header");

  a_chain_packed: assert property (@(posedge clk) disable iff (rst)
    ((cv >> 1) & ~cv) == '0)
    else $error("hole in byte chain");
`endif

endmodule

// ===== bench/servo_position_packet_framer_tb.sv =====
`timescale 1ns / 1ps

module servo_position_packet_framer_tb;

  import spf_pkg::*;

  localparam logic [7:0] SYNC_BYTE     = 8'hFF;
  localparam logic [7:0] LENGTH_FIELD  = 8'h09;
  localparam logic [7:0] WRITE_INSTR   = 8'h03;
  localparam logic [7:0] GOAL_POS_ADDR = 8'h2A;
  localparam logic [7:0] PAD_BYTE      = 8'h00;

  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int PRINT_CAP     = 40;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic pkt_valid;
  logic pkt_ready = 1'b0;
  pkt_t pkt;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register mirror, starts at the reset values
  logic [SERVO_COUNT-1:0] high_first = 7'h54;
  logic [SPD_W-1:0] servo_speed [SERVO_COUNT] =
    '{16'd0, 16'd0, 16'd0, 16'd1023, 16'd0, 16'd1023, 16'd0};

  pkt_t expected_bytes [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int absent_requests = 0;
  int bytes_checked = 0;
  int packets_checked = 0;
  int settings_used = 1;

  servo_position_packet_framer i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    pkt_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout with %0d bytes outstanding", expected_bytes.size());
    $display("[servo_position_packet_framer] ERROR");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch on %s, byte %0d of the run: got %02h, want %02h",
               what, bytes_checked, got, want);
  endtask

  // builds the write-position packet for one request
  function automatic void frame_packet(req_t r);
    logic [7:0] frame [PKT_LEN];
    logic [SPD_W-1:0] speed;
    logic [POS_W-1:0] pos;
    logic [7:0] sum;
    logic hi_first;
    pkt_t item;
    if (r.servo_index >= SERVO_COUNT) begin
      absent_requests++;
      return;
    end
    speed = servo_speed[r.servo_index];
    pos = r.target_position;
    hi_first = high_first[r.servo_index];
    frame[0] = SYNC_BYTE;
    frame[1] = SYNC_BYTE;
    frame[2] = {5'd0, r.servo_index} + 8'd1;
    frame[3] = LENGTH_FIELD;
    frame[4] = WRITE_INSTR;
    frame[5] = GOAL_POS_ADDR;
    frame[6] = hi_first ? pos[15:8] : pos[7:0];
    frame[7] = hi_first ? pos[7:0] : pos[15:8];
    frame[8] = PAD_BYTE;
    frame[9] = PAD_BYTE;
    frame[10] = hi_first ? speed[15:8] : speed[7:0];
    frame[11] = hi_first ? speed[7:0] : speed[15:8];
    sum = 8'd0;
    for (int i = 2; i < PKT_LEN - 1; i++)
      sum = sum + frame[i];
    frame[PKT_LEN-1] = ~sum;
    for (int i = 0; i < PKT_LEN; i++) begin
      item.packet_byte = frame[i];
      item.last_byte = (i == PKT_LEN - 1);
      expected_bytes.push_back(item);
    end
  endfunction

  always @(posedge clk) begin : check_bytes
    pkt_t want;
    if (!rst) begin
      if (req_valid && req_ready)
        frame_packet(req);
      if (pkt_valid && pkt_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("byte with no request", pkt.packet_byte, 0);
        end else begin
          want = expected_bytes.pop_front();
          if (pkt.packet_byte !== want.packet_byte)
            report_mismatch("packet_byte", pkt.packet_byte, want.packet_byte);
          if (pkt.last_byte !== want.last_byte)
            report_mismatch("last_byte", pkt.last_byte, want.last_byte);
          if (want.last_byte)
            packets_checked++;
        end
        bytes_checked++;
      end
    end
  end

  task automatic send_request(logic [IDX_W-1:0] idx, logic [POS_W-1:0] pos);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct)
      gap++;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req.servo_index <= idx;
    req.target_position <= pos;
    do @(posedge clk); while (!req_ready);
    requests_sent++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_bytes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_registers(logic [CFG_DATA_W-1:0] mask_word,
                                   logic [SERVO_COUNT-1:0][SPD_W-1:0] speeds);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= REG_HIGH_FIRST_MASK;
    cfg_data <= mask_word;
    @(posedge clk);
    high_first = mask_word[SERVO_COUNT-1:0];
    for (int i = 0; i < SERVO_COUNT; i++) begin
      cfg_index <= REG_SPEED_BASE + CFG_IDX_W'(i);
      cfg_data <= speeds[i];
      @(posedge clk);
      servo_speed[i] = speeds[i];
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_reset_settings();
    idle_pct = 0;
    stall_pct = 0;
    for (int s = 0; s < SERVO_COUNT; s++)
      send_request(IDX_W'(s), (s % 2 == 0) ? 16'hFFFF : 16'h0000);
    // index past the last servo is taken silently
    send_request(3'd7, 16'h1234);
  endtask

  task automatic test_field_extremes();
    logic [SERVO_COUNT-1:0][SPD_W-1:0] speeds;
    idle_pct = 37;
    stall_pct = 37;
    for (int i = 0; i < SERVO_COUNT; i++)
      speeds[i] = 16'hFFFF;
    program_registers(16'h0000, speeds);
    send_request(3'd0, 16'h0000);
    send_request(3'd6, 16'hFFFF);
    send_request(3'd3, 16'h00FF);
    for (int i = 0; i < SERVO_COUNT; i++)
      speeds[i] = 16'h0000;
    // bits above the mask width are dropped
    program_registers(16'hFFFF, speeds);
    send_request(3'd0, 16'hFFFF);
    send_request(3'd6, 16'h0000);
    send_request(3'd2, 16'hFF00);
    send_request(3'd7, 16'hFFFF);
    for (int i = 0; i < SERVO_COUNT; i++)
      speeds[i] = (i % 2 == 0) ? 16'h00FF : 16'h8001;
    program_registers(16'hFF2A, speeds);
    send_request(3'd1, 16'h8001);
    send_request(3'd2, 16'h7FFE);
    send_request(3'd5, 16'h0100);
    send_request(3'd4, 16'hFEFF);
  endtask

  task automatic test_random_traffic();
    logic [SERVO_COUNT-1:0][SPD_W-1:0] speeds;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos;
    int idle_by_phase [4];
    int stall_by_phase [4];
    idle_by_phase = '{0, 69, 0, 37};
    stall_by_phase = '{0, 0, 69, 37};
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < SERVO_COUNT; i++)
        speeds[i] = pick_word();
      program_registers(16'($urandom), speeds);
      idle_pct = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      for (int n = 0; n < 75; n++) begin
        idx = ($urandom_range(9) == 0) ? 3'd7 : IDX_W'($urandom_range(SERVO_COUNT - 1));
        pos = ($urandom_range(7) == 0) ? pick_word() : 16'($urandom);
        send_request(idx, pos);
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_field_extremes();
    test_random_traffic();
    $display("sent %0d position requests (%0d to an absent servo) over %0d register settings",
             requests_sent, absent_requests, settings_used);
    $display("checked %0d packets, %0d bytes, %0d mismatches",
             packets_checked, bytes_checked, mismatches);
    if (mismatches == 0)
      $display("[servo_position_packet_framer] OK");
    else
      $display("[servo_position_packet_framer] ERROR");
    $finish;
  end

endmodule
